// ===== design/ftcs_pkg.sv =====
package ftcs_pkg;

    // Floor point and step: Q16.24 two's complement
    localparam int POINT_W = 40;
    localparam int FRAC_W  = 24;
    localparam int CELL_W  = 16;
    localparam int TEX_W   = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_W_LOG2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_H_LOG2 = 3'd7;

    localparam logic CMD_START_ROW  = 1'b0;
    localparam logic CMD_NEXT_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE
    } seq_state_t;

    // Order in which the four row-setup divisions run
    typedef enum logic [1:0] {
        DIV_OFF_X,
        DIV_OFF_Y,
        DIV_STEP_X,
        DIV_STEP_Y
    } div_sel_t;

endpackage

// ===== design/ftcs_divider.sv =====
module ftcs_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [NUM_W-1:0]            num_mag,
    input  logic                        num_neg,
    input  logic [DEN_W-1:0]            den,
    output logic                        done,
    output logic [ftcs_pkg::POINT_W-1:0] quotient
);
    import ftcs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] count_reg;
    logic             run_reg;
    logic             neg_reg;
    logic             done_reg;

    logic [DEN_W:0]       shifted;
    logic                 fits;
    logic [POINT_W-1:0]   quo_ext;

    // Restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg   <= '0;
                quo_reg   <= num_mag;
                den_reg   <= den;
                neg_reg   <= num_neg;
                count_reg <= CNT_W'(NUM_W);
                run_reg   <= 1'b1;
            end else if (run_reg) begin
                rem_reg   <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
                quo_reg   <= {quo_reg[NUM_W-2:0], fits};
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo_ext  = POINT_W'(quo_reg);
    assign quotient = neg_reg ? POINT_W'(-quo_ext) : quo_ext;
    assign done     = done_reg;

endmodule

// ===== design/floor_texture_coord_stepper_unit.sv =====
// Pixel transaction: one per cycle while the result side keeps up.
// Row-start transaction: four serial divisions on one shared restoring divider;
// input not ready meanwhile.
// Result is registered and delivered in the cycle after the pixel is accepted.
// Reset (aresetn, synchronous, active low) clears control state and sets the
// configuration registers to a default camera; no row is active after reset.
module floor_texture_coord_stepper_unit #(
    parameter int SCREEN_W = 640,
    parameter int SCREEN_H = 480
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ftcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ftcs_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [8:0]                        s_row,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [9:0]                        m_column,
    output logic [8:0]                        m_screen_row,
    output logic signed [15:0]                m_cell_x,
    output logic signed [15:0]                m_cell_y,
    output logic [9:0]                        m_tex_x,
    output logic [9:0]                        m_tex_y,
    output logic                              m_last
);
    import ftcs_pkg::*;

    localparam int ROW_CMP_W = 11;
    localparam int HORIZON   = SCREEN_H / 2;
    localparam int H_W       = $clog2(SCREEN_H + 1);
    localparam int NUM_W     = 17 + H_W + 10;
    localparam int YREL_W    = 9;
    localparam int DEN_W     = YREL_W + $clog2(SCREEN_W + 1);

    seq_state_t state_reg, state_next;
    div_sel_t   sel_reg, sel_next;

    logic [23:0]        pos_x_reg, pos_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [3:0]         tex_w_log2_reg, tex_h_log2_reg;

    logic [POINT_W-1:0] point_x_reg, point_y_reg, step_x_reg, step_y_reg;
    logic [9:0]         column_count_reg;
    logic [8:0]         current_row_reg;
    logic               row_active_reg;

    logic               m_valid_reg;
    logic [9:0]         column_out_reg;
    logic [8:0]         row_out_reg;
    logic [15:0]        cell_x_reg, cell_y_reg;
    logic [9:0]         tex_x_reg, tex_y_reg;
    logic               last_reg;

    logic               in_acc;
    logic               row_ok;
    logic               pix_out;
    logic               pix_last;
    logic [ROW_CMP_W-1:0] row_ext;
    logic [ROW_CMP_W-1:0] yrel_wide;
    logic [YREL_W-1:0]  yrel;

    logic signed [16:0] operand;
    logic [16:0]        op_mag;
    logic [NUM_W-1:0]   num_prod;
    logic [NUM_W-1:0]   num_mag;
    logic [DEN_W-1:0]   den;
    logic               div_start;
    logic               div_done;
    logic [POINT_W-1:0] quotient;
    logic [9:0]         tex_x_val, tex_y_val;

    assign in_acc   = s_valid && s_ready;
    assign row_ext  = ROW_CMP_W'(s_row);
    assign row_ok   = (row_ext > ROW_CMP_W'(HORIZON)) && (row_ext < ROW_CMP_W'(SCREEN_H));
    assign pix_out  = in_acc && (s_command == CMD_NEXT_PIXEL) && row_active_reg;
    assign pix_last = column_count_reg >= 10'(SCREEN_W - 1);

    assign yrel_wide = ROW_CMP_W'(current_row_reg) - ROW_CMP_W'(HORIZON);
    assign yrel      = yrel_wide[YREL_W-1:0];

    // Divider operands: offsets use H*rd*2^9/yrel, steps H*plane*2^10/(yrel*W)
    always_comb begin
        unique case (sel_reg)
            DIV_OFF_X:  operand = 17'(dir_x_reg) - 17'(plane_x_reg);
            DIV_OFF_Y:  operand = 17'(dir_y_reg) - 17'(plane_y_reg);
            DIV_STEP_X: operand = 17'(plane_x_reg);
            DIV_STEP_Y: operand = 17'(plane_y_reg);
            default:    operand = '0;
        endcase
        op_mag   = operand[16] ? 17'(-operand) : 17'(operand);
        num_prod = NUM_W'(op_mag) * NUM_W'(SCREEN_H);
        if (sel_reg == DIV_OFF_X || sel_reg == DIV_OFF_Y) begin
            num_mag = num_prod << 9;
            den     = DEN_W'(yrel);
        end else begin
            num_mag = num_prod << 10;
            den     = DEN_W'(yrel) * DEN_W'(SCREEN_W);
        end
    end

    ftcs_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num_mag  (num_mag),
        .num_neg  (operand[16]),
        .den      (den),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_command == CMD_START_ROW && row_ok) begin
                    state_next = ST_LOAD;
                    sel_next   = DIV_OFF_X;
                end
            end
            ST_LOAD: state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (div_done) begin
                    if (sel_reg == DIV_STEP_Y) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_LOAD;
                        sel_next   = div_sel_t'(sel_reg + 2'd1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready   = !m_valid_reg || m_ready;
            ST_LOAD:   div_start = 1'b1;
            ST_DIVIDE: div_start = 1'b0;
            default:   s_ready   = 1'b0;
        endcase
    end

    assign cfg_ready = 1'b1;

    assign tex_x_val = 10'(point_x_reg[FRAC_W-1:0] >> (5'd24 - {1'b0, tex_w_log2_reg}));
    assign tex_y_val = 10'(point_y_reg[FRAC_W-1:0] >> (5'd24 - {1'b0, tex_h_log2_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sel_reg          <= DIV_OFF_X;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            dir_x_reg        <= 16'sd16384;
            dir_y_reg        <= '0;
            plane_x_reg      <= '0;
            plane_y_reg      <= 16'sd10813;
            tex_w_log2_reg   <= 4'd6;
            tex_h_log2_reg   <= 4'd6;
            point_x_reg      <= '0;
            point_y_reg      <= '0;
            step_x_reg       <= '0;
            step_y_reg       <= '0;
            column_count_reg <= '0;
            current_row_reg  <= '0;
            row_active_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_POS_X:      pos_x_reg      <= cfg_data;
                    REG_POS_Y:      pos_y_reg      <= cfg_data;
                    REG_DIR_X:      dir_x_reg      <= cfg_data[15:0];
                    REG_DIR_Y:      dir_y_reg      <= cfg_data[15:0];
                    REG_PLANE_X:    plane_x_reg    <= cfg_data[15:0];
                    REG_PLANE_Y:    plane_y_reg    <= cfg_data[15:0];
                    REG_TEX_W_LOG2: tex_w_log2_reg <= cfg_data[3:0];
                    REG_TEX_H_LOG2: tex_h_log2_reg <= cfg_data[3:0];
                    default:        ;
                endcase
            end

            if (in_acc && s_command == CMD_START_ROW) begin
                row_active_reg <= 1'b0;
                if (row_ok) begin
                    current_row_reg <= s_row;
                end
            end

            if (pix_out) begin
                column_out_reg <= column_count_reg;
                row_out_reg    <= current_row_reg;
                cell_x_reg     <= point_x_reg[POINT_W-1 -: CELL_W];
                cell_y_reg     <= point_y_reg[POINT_W-1 -: CELL_W];
                tex_x_reg      <= tex_x_val;
                tex_y_reg      <= tex_y_val;
                last_reg       <= pix_last;
                point_x_reg    <= point_x_reg + step_x_reg;
                point_y_reg    <= point_y_reg + step_y_reg;
                if (pix_last) begin
                    row_active_reg <= 1'b0;
                end else begin
                    column_count_reg <= column_count_reg + 1'b1;
                end
            end

            // Commit each quotient as it comes out of the divider
            if (div_done) begin
                unique case (sel_reg)
                    DIV_OFF_X:  point_x_reg <= {8'd0, pos_x_reg, 8'd0} + quotient;
                    DIV_OFF_Y:  point_y_reg <= {8'd0, pos_y_reg, 8'd0} + quotient;
                    DIV_STEP_X: step_x_reg  <= quotient;
                    DIV_STEP_Y: begin
                        step_y_reg       <= quotient;
                        column_count_reg <= '0;
                        row_active_reg   <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (pix_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_column     = column_out_reg;
    assign m_screen_row = row_out_reg;
    assign m_cell_x     = cell_x_reg;
    assign m_cell_y     = cell_y_reg;
    assign m_tex_x      = tex_x_reg;
    assign m_tex_y      = tex_y_reg;
    assign m_last       = last_reg;

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide state");

    a_result_from_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(pix_out))
        else $error("result appeared without an accepted pixel transaction");

    a_row_closed_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_out && pix_last |=> !row_active_reg)
        else $error("row still active after its last pixel");

    a_no_pixel_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !pix_out)
        else $error("pixel transaction taken during row setup");

endmodule
